>>> rtl/core/fsrs_pkg.sv
// ----------------------------------------------------------------------------
// fsrs_pkg
// shared types and constants of the flash sector read-modify-write sequencer
// ----------------------------------------------------------------------------
package fsrs_pkg;

    localparam int unsigned SECTOR_BYTES_DEF = 4096;
    localparam int unsigned PAGE_BYTES_DEF   = 256;

    localparam logic OPC_START   = 1'b0;
    localparam logic OPC_ADVANCE = 1'b1;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_ERASE = 3'd1;
    localparam logic [2:0] OP_MERGE = 3'd2;
    localparam logic [2:0] OP_PROG  = 3'd3;
    localparam logic [2:0] OP_IDLE  = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_READ  = 3'd1,
        PH_ERASE = 3'd2,
        PH_MERGE = 3'd3,
        PH_PROG  = 3'd4
    } t_phase;

    typedef struct packed {
        logic        opcode;
        logic [31:0] start_address;
        logic [15:0] byte_count;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] flash_address;
        logic [31:0] bus_address;
        logic [11:0] buffer_offset;
        logic [15:0] source_offset;
        logic [12:0] length;
        logic        last;
    } t_out_item;

endpackage

>>> rtl/core/fsrs_core.sv
// ----------------------------------------------------------------------------
// fsrs_core
// request state and next operation for one accepted item
// ----------------------------------------------------------------------------
module fsrs_core import fsrs_pkg::*; #(
    parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic [31:0] i_mapped_base,
    output t_out_item   o_result
);

    localparam int unsigned SECT_W     = $clog2(SECTOR_BYTES);
    localparam int unsigned SNUM_W     = 32 - SECT_W;
    localparam int unsigned CHUNK_W    = SECT_W + 1;
    localparam int unsigned PAGES      = (SECTOR_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int unsigned PAGE_IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;

    t_phase                  r_phase,         n_phase;
    logic [SNUM_W-1:0]       r_sector_number, n_sector_number;
    logic [SECT_W-1:0]       r_sector_offset, n_sector_offset;
    logic [CHUNK_W-1:0]      r_chunk_bytes,   n_chunk_bytes;
    logic [15:0]             r_bytes_left,    n_bytes_left;
    logic [15:0]             r_source_pos,    n_source_pos;
    logic [PAGE_IDX_W-1:0]   r_page_index,    n_page_index;

    logic [31:0] base;
    logic [31:0] page_off;
    logic [31:0] page_len;
    logic [31:0] off_ext;
    logic [31:0] chunk_ext;
    logic [16:0] start_room;
    logic [16:0] start_count;
    logic [16:0] left_ext;
    logic [16:0] chunk17;
    logic [16:0] src_sum;
    logic [16:0] left_diff;
    logic [16:0] next_chunk;
    logic        last_page;

    always_comb begin
        base        = {r_sector_number, SECT_W'(0)};
        page_off    = 32'(r_page_index) * 32'(PAGE_BYTES);
        page_len    = 32'(SECTOR_BYTES) - page_off;
        if (page_len > 32'(PAGE_BYTES)) begin
            page_len = 32'(PAGE_BYTES);
        end
        off_ext     = 32'(r_sector_offset);
        chunk_ext   = 32'(r_chunk_bytes);
        start_room  = 17'(SECTOR_BYTES) - 17'(i_item.start_address[SECT_W-1:0]);
        start_count = {1'b0, i_item.byte_count};
        left_ext    = {1'b0, r_bytes_left};
        chunk17     = 17'(r_chunk_bytes);
        src_sum     = 17'(r_source_pos) + chunk17;
        left_diff   = left_ext - chunk17;
        next_chunk  = (left_diff <= 17'(SECTOR_BYTES)) ? left_diff : 17'(SECTOR_BYTES);
        last_page   = (r_page_index == PAGE_IDX_W'(PAGES - 1));
    end

    always_comb begin
        n_phase         = r_phase;
        n_sector_number = r_sector_number;
        n_sector_offset = r_sector_offset;
        n_chunk_bytes   = r_chunk_bytes;
        n_bytes_left    = r_bytes_left;
        n_source_pos    = r_source_pos;
        n_page_index    = r_page_index;
        o_result        = '0;
        o_result.operation = OP_IDLE;

        if (i_item.opcode == OPC_START) begin
            n_sector_number = i_item.start_address[31:SECT_W];
            n_sector_offset = i_item.start_address[SECT_W-1:0];
            n_bytes_left    = i_item.byte_count;
            n_source_pos    = '0;
            n_chunk_bytes   = (start_count <= start_room) ? CHUNK_W'(start_count)
                                                          : CHUNK_W'(start_room);
            n_page_index    = '0;
            n_phase         = PH_READ;
        end else begin
            case (r_phase)
                PH_READ: begin
                    o_result.operation     = OP_READ;
                    o_result.flash_address = base;
                    o_result.bus_address   = i_mapped_base + base;
                    o_result.length        = 13'(SECTOR_BYTES);
                    n_phase                = PH_ERASE;
                end
                PH_ERASE: begin
                    o_result.operation     = OP_ERASE;
                    o_result.flash_address = base;
                    o_result.length        = 13'(SECTOR_BYTES);
                    n_phase                = PH_MERGE;
                end
                PH_MERGE: begin
                    o_result.operation     = OP_MERGE;
                    o_result.flash_address = base;
                    o_result.buffer_offset = off_ext[11:0];
                    o_result.source_offset = r_source_pos;
                    o_result.length        = chunk_ext[12:0];
                    n_page_index           = '0;
                    n_phase                = PH_PROG;
                end
                PH_PROG: begin
                    o_result.operation     = OP_PROG;
                    o_result.flash_address = base + page_off;
                    o_result.buffer_offset = page_off[11:0];
                    o_result.length        = page_len[12:0];
                    if (!last_page) begin
                        n_page_index = r_page_index + 1'b1;
                    end else if (left_ext <= chunk17) begin
                        o_result.last = 1'b1;
                        n_phase       = PH_IDLE;
                        n_page_index  = '0;
                    end else begin
                        n_source_pos    = src_sum[15:0];
                        n_bytes_left    = left_diff[15:0];
                        n_sector_number = r_sector_number + 1'b1;
                        n_sector_offset = '0;
                        n_chunk_bytes   = CHUNK_W'(next_chunk);
                        n_page_index    = '0;
                        n_phase         = PH_READ;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_sector_number <= '0;
            r_sector_offset <= '0;
            r_chunk_bytes   <= '0;
            r_bytes_left    <= '0;
            r_source_pos    <= '0;
            r_page_index    <= '0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_sector_number <= n_sector_number;
            r_sector_offset <= n_sector_offset;
            r_chunk_bytes   <= n_chunk_bytes;
            r_bytes_left    <= n_bytes_left;
            r_source_pos    <= n_source_pos;
            r_page_index    <= n_page_index;
        end
    end

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.opcode == OPC_START |=> r_phase == PH_READ)
        else $error("start item did not arm the read phase");

    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_page_index <= PAGE_IDX_W'(PAGES - 1))
        else $error("page index beyond sector");

    a_chunk_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_chunk_bytes) + 32'(r_sector_offset) <= 32'(SECTOR_BYTES))
        else $error("merge chunk crosses sector end");

    a_idle_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_PROG |-> r_page_index == '0)
        else $error("page index not cleared outside program phase");

endmodule

>>> rtl/core/flash_sector_rmw_sequencer.sv
// ----------------------------------------------------------------------------
// flash_sector_rmw_sequencer
// yields the read, erase, merge and page program steps of a nor flash write
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid / o_in_stall  t_in_item
//   out      output     o_out_valid / i_out_stall t_out_item
//   cfg      input      i_cfg_valid / o_cfg_ready mapped_base (32 bit)
//
// one item per cycle unless stalled; its result shows in the next cycle
// the operation is formed by a single combinational pass from request state
// input stalls only while a result is held and the output is stalled
// synchronous active-low reset returns the request state to idle
// ----------------------------------------------------------------------------
module flash_sector_rmw_sequencer import fsrs_pkg::*; #(
    parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [31:0] r_mapped_base;
    logic        accept;
    t_out_item   result;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    fsrs_core #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_mapped_base (r_mapped_base),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_mapped_base <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mapped_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= result;
        end
    end

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && !accept)
        else $error("input stalled without a held result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_stall && !accept |=> !r_out_valid)
        else $error("taken result not retired");

endmodule
